// ===== rtl/overwrite_ring_fifo_defines.svh =====
`ifndef OVERWRITE_RING_FIFO_DEFINES_SVH
`define OVERWRITE_RING_FIFO_DEFINES_SVH

// same-cycle implication
`define ORF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ORF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/orf_pkg.sv =====
package orf_pkg;

   localparam int BYTE_W     = 8;
   localparam int CAP_W      = 10;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(512);
   localparam logic [CAP_W-1:0] CAP_MIN   = CAP_W'(2);

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   localparam logic REG_CAPACITY = 1'b0;

endpackage

// ===== rtl/orf_req_if.sv =====
interface orf_req_if;
   import orf_pkg::*;

   logic              valid;
   logic              ready;
   logic              req_type;
   logic [BYTE_W-1:0] data_in;

   modport source (output valid, output req_type, output data_in, input ready);
   modport sink   (input valid, input req_type, input data_in, output ready);
endinterface

// ===== rtl/orf_rsp_if.sv =====
interface orf_rsp_if;
   import orf_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_out;
   logic              got_item;
   logic              overwrote;
   logic [CAP_W-1:0]  fill_count;

   modport source (output valid, output data_out, output got_item, output overwrote,
                   output fill_count, input ready);
   modport sink   (input valid, input data_out, input got_item, input overwrote,
                   input fill_count, output ready);
endinterface

// ===== rtl/overwrite_ring_fifo.sv =====
// Byte FIFO on a circular store of DEPTH entries, wrapping at the capacity register
// (clamped to 2..DEPTH); a push into a full FIFO drops the oldest byte and flags
// overwrote, a pop of an empty FIFO answers got_item 0 and data 0. One request is
// taken every cycle and its single result appears in the output register on the
// next cycle; a result left waiting holds off further requests, since the popped
// byte sits in the read register of the single-port-pair store. The store is not
// cleared at reset, so no clearing pass is needed and requests are taken at once.
module overwrite_ring_fifo #(
   parameter int DEPTH = 512
) (
   input  logic                            clock,
   input  logic                            reset,
   orf_req_if.sink                         req_ch,
   orf_rsp_if.source                       rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [orf_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [orf_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [orf_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import orf_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);

   logic [CAP_W-1:0]  cap_use;
   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   logic [BYTE_W-1:0] ram_wdata;
   logic              ram_re;
   logic [IDX_W-1:0]  ram_raddr;
   logic [BYTE_W-1:0] ram_rdata;

   orf_csr #(.DEPTH(DEPTH)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cap_use     (cap_use)
   );

   orf_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cap_use   (cap_use),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   orf_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

endmodule

// ===== rtl/orf_ram.sv =====
module orf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/orf_csr.sv =====
module orf_csr #(
   parameter int DEPTH = 512
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [orf_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [orf_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [orf_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output logic [orf_pkg::CAP_W-1:0]       cap_use
);
   import orf_pkg::*;

   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [CAP_W-1:0] cap_use_ff, cap_use_in;
   logic             wr_hit;
   logic             reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[2];
   assign wr_hit     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (reg_idx == REG_CAPACITY);

   // clamp to 2..DEPTH once, at write time
   always_comb begin
      cap_in     = cap_ff;
      cap_use_in = cap_use_ff;
      if (wr_hit) begin
         cap_in = csr_pwdata[CAP_W-1:0];
         if (cap_in < CAP_MIN) begin
            cap_use_in = CAP_MIN;
         end else if (32'(cap_in) > DEPTH) begin
            cap_use_in = CAP_W'(DEPTH);
         end else begin
            cap_use_in = cap_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff     <= CAP_RESET;
         cap_use_ff <= (32'(CAP_RESET) > DEPTH) ? CAP_W'(DEPTH) : CAP_RESET;
      end else begin
         cap_ff     <= cap_in;
         cap_use_ff <= cap_use_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_idx == REG_CAPACITY) begin
         csr_prdata = CSR_DATA_W'(cap_ff);
      end
   end

   assign cap_use = cap_use_ff;

endmodule

// ===== rtl/orf_ctrl.sv =====
`include "overwrite_ring_fifo_defines.svh"

module orf_ctrl #(
   parameter int DEPTH = 512
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [orf_pkg::CAP_W-1:0]        cap_use,
   orf_req_if.sink                          req,
   orf_rsp_if.source                        rsp,
   output logic                             ram_we,
   output logic [$clog2(DEPTH)-1:0]         ram_waddr,
   output logic [orf_pkg::BYTE_W-1:0]       ram_wdata,
   output logic                             ram_re,
   output logic [$clog2(DEPTH)-1:0]         ram_raddr,
   input  logic [orf_pkg::BYTE_W-1:0]       ram_rdata
);
   import orf_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);

   logic [IDX_W-1:0] wr_ff, wr_in;
   logic [IDX_W-1:0] rd_ff, rd_in;
   logic [CAP_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             got_ff, got_in;
   logic             over_ff, over_in;
   logic [CAP_W-1:0] fill_ff;
   logic             accept;

   function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] idx,
                                           input logic [CAP_W-1:0] cap);
      logic [IDX_W-1:0] nxt;
      nxt = idx + 1'b1;
      if (32'(idx) >= 32'(cap) - 32'd1) begin
         nxt = '0;
      end
      return nxt;
   endfunction

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   always_comb begin
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      cnt_in  = cnt_ff;
      got_in  = 1'b0;
      over_in = 1'b0;
      ram_we  = 1'b0;
      ram_re  = 1'b0;
      if (accept) begin
         if (req.req_type == REQ_PUSH) begin
            if (cnt_ff >= cap_use) begin
               rd_in   = adv(rd_ff, cap_use);
               cnt_in  = cap_use;
               over_in = 1'b1;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
            wr_in  = adv(wr_ff, cap_use);
            ram_we = 1'b1;
         end else if (cnt_ff != '0) begin
            ram_re = 1'b1;
            rd_in  = adv(rd_ff, cap_use);
            cnt_in = cnt_ff - 1'b1;
            got_in = 1'b1;
         end
      end
   end

   // write pointer names the newest byte
   assign ram_waddr = wr_in;
   assign ram_wdata = req.data_in;
   assign ram_raddr = rd_ff;

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff        <= '0;
         rd_ff        <= IDX_W'(1);
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ff        <= wr_in;
         rd_ff        <= rd_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         got_ff  <= got_in;
         over_ff <= over_in;
         fill_ff <= cnt_in;
      end
   end

   // ram read data holds while the result is stalled
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.data_out   = got_ff ? ram_rdata : '0;
   assign rsp.got_item   = got_ff;
   assign rsp.overwrote  = over_ff;
   assign rsp.fill_count = fill_ff;

   `ORF_ASSERT_NOW(a_one_port, clock, reset, 1'b1, !(ram_we && ram_re),
      "read and write issued together")
   `ORF_ASSERT_NOW(a_fill_mirror, clock, reset, rsp_valid_ff, fill_ff == cnt_ff,
      "reported fill differs from count")
   `ORF_ASSERT_NEXT(a_pop_hit, clock, reset,
      accept && (req.req_type == REQ_POP) && (cnt_ff != '0),
      got_ff && !over_ff && (fill_ff == $past(cnt_ff) - 1'b1),
      "pop of non-empty fifo misreported")
   `ORF_ASSERT_NEXT(a_push_full, clock, reset,
      accept && (req.req_type == REQ_PUSH) && (cnt_ff >= cap_use),
      over_ff && !got_ff && (fill_ff == $past(cap_use)),
      "overwriting push misreported")

endmodule

// ===== tb/sv/orf_ring_checker.sv =====
`timescale 1ns / 1ps

module orf_ring_checker #(
   parameter int DEPTH = 512
) (
   input  logic                           clock,
   input  logic                           reset,
   orf_req_if                             req_ch,
   orf_rsp_if                             rsp_ch,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [orf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [orf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic [orf_pkg::CSR_DATA_W-1:0] csr_prdata,
   input  logic                           csr_pready,
   output int                             replies_due,
   output int                             fault_count
);
   import orf_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] CAPACITY_ADDR = CSR_ADDR_W'(4 * REG_CAPACITY);

   typedef struct packed {
      logic [BYTE_W-1:0] data_out;
      logic              got_item;
      logic              overwrote;
      logic [CAP_W-1:0]  fill_count;
   } fifo_reply_type;

   logic [BYTE_W-1:0] ring_bytes [DEPTH];
   int unsigned       newest_slot;
   int unsigned       oldest_slot;
   int unsigned       held;
   logic [CAP_W-1:0]  capacity_reg;
   fifo_reply_type    replies_q [$];
   int                faults = 0;

   function automatic int unsigned live_capacity();
      int unsigned lim;
      lim = capacity_reg;
      if (lim < CAP_MIN)
         lim = CAP_MIN;
      if (lim > DEPTH)
         lim = DEPTH;
      return lim;
   endfunction

   // any slot at or past the wrap point goes back to 0
   function automatic int unsigned step_slot(int unsigned slot, int unsigned lim);
      return (slot >= lim - 1) ? 0 : slot + 1;
   endfunction

   function automatic fifo_reply_type next_fifo_reply(logic kind, logic [BYTE_W-1:0] din);
      fifo_reply_type r;
      int unsigned    lim;
      lim = live_capacity();
      r = '0;
      if (kind == REQ_PUSH) begin
         if (held >= lim) begin
            oldest_slot = step_slot(oldest_slot, lim);
            held = lim;
            r.overwrote = 1'b1;
         end else begin
            held++;
         end
         newest_slot = step_slot(newest_slot, lim);
         ring_bytes[newest_slot] = din;
      end else if (held > 0) begin
         r.data_out = ring_bytes[oldest_slot];
         oldest_slot = step_slot(oldest_slot, lim);
         held--;
         r.got_item = 1'b1;
      end
      r.fill_count = CAP_W'(held);
      return r;
   endfunction

   function automatic void compare_field(string field, logic [CAP_W-1:0] want,
                                         logic [CAP_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         faults++;
      end
   endfunction

   always @(posedge clock) begin
      fifo_reply_type want;
      if (reset) begin
         newest_slot = 0;
         oldest_slot = 1;
         held = 0;
         capacity_reg = CAP_RESET;
         replies_q.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (replies_q.size() == 0) begin
               $error("reply with no request outstanding");
               faults++;
            end else begin
               want = replies_q.pop_front();
               compare_field("data_out", CAP_W'(want.data_out), CAP_W'(rsp_ch.data_out));
               compare_field("got_item", CAP_W'(want.got_item), CAP_W'(rsp_ch.got_item));
               compare_field("overwrote", CAP_W'(want.overwrote), CAP_W'(rsp_ch.overwrote));
               compare_field("fill_count", want.fill_count, rsp_ch.fill_count);
            end
         end
         if (req_ch.valid && req_ch.ready)
            replies_q.push_back(next_fifo_reply(req_ch.req_type, req_ch.data_in));
         if (csr_psel && csr_penable && csr_pready && csr_paddr == CAPACITY_ADDR) begin
            if (csr_pwrite) begin
               capacity_reg = csr_pwdata[CAP_W-1:0];
            end else if (csr_prdata !== CSR_DATA_W'(capacity_reg)) begin
               $error("capacity: expected %0d, got %0d", capacity_reg, csr_prdata);
               faults++;
            end
         end
      end
      replies_due <= replies_q.size();
      fault_count <= faults;
   end

endmodule

// ===== tb/sv/overwrite_ring_fifo_test.sv =====
`timescale 1ns / 1ps

module overwrite_ring_fifo_test;
   import orf_pkg::*;

   localparam int DEPTH        = 512;
   localparam int STALL_LIMIT  = 1000;
   localparam int RANDOM_ITEMS = 660;
   localparam int CALM_AFTER   = 560;
   localparam logic [CSR_ADDR_W-1:0] CAPACITY_ADDR = CSR_ADDR_W'(4 * REG_CAPACITY);

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    replies_due;
   int                    fault_count;
   bit                    calm = 1'b0;
   int                    dead_cycles = 0;

   orf_req_if req_ch ();
   orf_rsp_if rsp_ch ();

   always #5 clock = ~clock;

   overwrite_ring_fifo #(.DEPTH(DEPTH)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   orf_ring_checker #(.DEPTH(DEPTH)) u_check (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .replies_due (replies_due),
      .fault_count (fault_count)
   );

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_psel && csr_penable)) begin
         dead_cycles <= 0;
      end else if (dead_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         dead_cycles <= dead_cycles + 1;
      end
   end

   // reply back-pressure
   initial begin : reply_stalls
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   task automatic send_request(logic kind, logic [BYTE_W-1:0] payload);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= kind;
      req_ch.data_in  <= payload;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (replies_due != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_access(logic wr, logic [CSR_DATA_W-1:0] wdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= CAPACITY_ADDR;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // opening phases hit clamping and shrinking under a full ring
   function automatic logic [CAP_W-1:0] pick_capacity(int unsigned phase_no);
      case (phase_no)
         0:       return CAP_W'(3);
         1:       return CAP_MIN;
         2:       return CAP_W'(0);
         3:       return CAP_W'(1);
         4:       return '1;
         5:       return CAP_W'(513);
         6:       return CAP_RESET;
         7:       return CAP_W'(7);
         8:       return CAP_MIN;
         default: begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: return CAP_W'($urandom_range(2, 16));
               6, 7:             return CAP_W'($urandom_range(17, 512));
               8:                return CAP_W'($urandom_range(0, 1023));
               default:          return CAP_RESET;
            endcase
         end
      endcase
   endfunction

   initial begin : stimulus
      int unsigned           sent;
      int unsigned           phase_no;
      int unsigned           pop_odds;
      logic [CSR_DATA_W-1:0] wdata;

      req_ch.valid    = 1'b0;
      req_ch.req_type = REQ_PUSH;
      req_ch.data_in  = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_request(REQ_POP, 8'hFF);
      send_request(REQ_PUSH, 8'h00);
      send_request(REQ_PUSH, 8'hFF);
      send_request(REQ_PUSH, 8'h80);
      send_request(REQ_PUSH, 8'h01);
      send_request(REQ_PUSH, 8'h55);
      send_request(REQ_PUSH, 8'hAA);
      repeat (7) send_request(REQ_POP, BYTE_W'($urandom));
      send_request(REQ_PUSH, 8'h7F);
      send_request(REQ_POP, 8'h00);
      wait_drained();
      csr_access(1'b0, '0);

      // every slot written before the wrap point is ever moved
      repeat (DEPTH + 8) send_request(REQ_PUSH, BYTE_W'($urandom));

      sent = 0;
      phase_no = 0;
      pop_odds = 50;
      while (sent < RANDOM_ITEMS) begin
         if (sent < CALM_AFTER) begin
            wait_drained();
            wdata = $urandom;
            wdata[CAP_W-1:0] = pick_capacity(phase_no);
            csr_access(1'b1, wdata);
            if ($urandom_range(0, 2) == 0)
               csr_access(1'b0, '0);
            case ($urandom_range(0, 2))
               0:       pop_odds = 10;
               1:       pop_odds = 50;
               default: pop_odds = 80;
            endcase
         end
         repeat ($urandom_range(20, 80)) begin
            if (sent >= CALM_AFTER)
               calm <= 1'b1;
            send_request(($urandom_range(0, 99) < pop_odds) ? REQ_POP : REQ_PUSH,
                         BYTE_W'($urandom));
            sent++;
            if (!calm && $urandom_range(0, 149) == 0)
               wait_drained();
         end
         phase_no++;
      end

      req_ch.valid <= 1'b0;
      do @(posedge clock); while (replies_due != 0);
      repeat (4) @(posedge clock);
      if (fault_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
